/* rtl/core/bgc_pkg.sv */
package bgc_pkg;

  localparam int VTX_W = 8;

  // Controller commands to the datapath
  typedef struct packed {
    logic load_edge;    // validate and store the input edge
    logic clear_color;  // clear one color entry (sweep)
    logic start_vtx;    // color the current start vertex, push frame
    logic scan_req;     // read the neighbor color of the registered edge word
    logic scan_eval;    // evaluate read edge against top frame
    logic pop;          // drop top frame
    logic next_start;   // advance the start vertex
    logic finish;       // empty edge store and error flag
  } bgc_cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic error_seen;
    logic clear_done;
    logic start_done;   // start vertex past bound
    logic start_colored;
    logic stack_empty;
    logic scan_end;     // top frame scanned every stored edge
    logic conflict;     // edge joins two same-colored vertices
  } bgc_stat_t;

endpackage

/* rtl/core/bgc_if.sv */
interface bgc_edge_if;
  logic                    valid;
  logic                    ready;
  logic                    edge_present;
  logic [bgc_pkg::VTX_W-1:0] end_a;
  logic [bgc_pkg::VTX_W-1:0] end_b;
  logic                    last_edge;
  modport source (output valid, edge_present, end_a, end_b, last_edge, input ready);
  modport sink (input valid, edge_present, end_a, end_b, last_edge, output ready);
endinterface

interface bgc_result_if;
  logic valid;
  logic ready;
  logic is_bipartite;
  logic load_error;
  modport source (output valid, is_bipartite, load_error, input ready);
  modport sink (input valid, is_bipartite, load_error, output ready);
endinterface

interface bgc_cfg_if;
  logic                    valid;
  logic                    ready;
  logic [bgc_pkg::VTX_W-1:0] vertex_count;
  modport source (output valid, vertex_count, input ready);
  modport sink (input valid, vertex_count, output ready);
endinterface

/* rtl/core/bgc_datapath.sv */
module bgc_datapath
  import bgc_pkg::*;
#(
  parameter int MAX_VERTICES = 256,
  parameter int MAX_EDGES    = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  bgc_cmd_t          cmd,
  output bgc_stat_t         stat,
  input  logic              in_present,
  input  logic [VTX_W-1:0]  in_a,
  input  logic [VTX_W-1:0]  in_b,
  input  logic [VTX_W-1:0]  vertex_count
);
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int EW = $clog2(MAX_EDGES);
  localparam int SW = VW + 1;   // stack depth counter
  localparam int TW = EW + 1;   // edge count / scan position

  // bound = min(vertex_count, MAX_VERTICES-1), compared at full width
  localparam int BW = (VW > VTX_W) ? VW : VTX_W;
  localparam logic [BW-1:0] VMAX = BW'(MAX_VERTICES - 1);

  logic [BW-1:0] bound;
  logic [BW-1:0] a_ext, b_ext;
  assign bound = (BW'(vertex_count) > VMAX) ? VMAX : BW'(vertex_count);
  assign a_ext = BW'(in_a);
  assign b_ext = BW'(in_b);

  // Edge store memory
  logic [2*VTX_W-1:0] edge_mem [MAX_EDGES];
  logic [2*VTX_W-1:0] edge_rd;
  logic [TW-1:0]      edge_total;
  logic               error_seen;

  // Colors memory; valid-bit free since cleared by sweep before walk
  logic [1:0] color_mem [MAX_VERTICES];
  logic [1:0] color_rd;
  logic [VW-1:0] clr_idx;
  logic          clear_done;

  // Stack memories: vertex and scan position
  logic [VW-1:0] stk_v [MAX_VERTICES];
  logic [TW-1:0] stk_s [MAX_VERTICES];
  logic [SW-1:0] depth;
  logic [VW-1:0] top_v;      // cached top frame
  logic [TW-1:0] top_s;
  logic [1:0]    top_c;      // color of top vertex
  logic          reload;     // top cache must be reloaded after pop
  logic [BW:0]   start_v;

  logic edge_ok, store_full;
  assign edge_ok    = (a_ext != '0) && (a_ext <= bound) && (b_ext != '0) && (b_ext <= bound);
  assign store_full = (edge_total == TW'(MAX_EDGES));

  always_ff @(posedge clk) begin
    if (cmd.load_edge && in_present && edge_ok && !store_full)
      edge_mem[edge_total[EW-1:0]] <= {in_a, in_b};
    edge_rd <= edge_mem[top_s[EW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_total <= '0;
      error_seen <= 1'b0;
    end else if (cmd.finish) begin
      edge_total <= '0;
      error_seen <= 1'b0;
    end else if (cmd.load_edge && in_present) begin
      if (edge_ok && !store_full) edge_total <= edge_total + 1'b1;
      else                        error_seen <= 1'b1;
    end
  end

  // Neighbor from the registered edge word
  logic [VTX_W-1:0] ea, eb, w8;
  logic             hit;
  assign ea  = edge_rd[2*VTX_W-1:VTX_W];
  assign eb  = edge_rd[VTX_W-1:0];
  assign hit = (BW'(ea) == BW'(top_v)) || (BW'(eb) == BW'(top_v));
  assign w8  = (BW'(ea) == BW'(top_v)) ? eb : ea;
  logic          w_in;
  logic [VW-1:0] w;
  assign w_in = (BW'(w8) <= VMAX);
  assign w    = VW'(w8);

  // color of w, registered by scan_req in the cycle before scan_eval
  logic [1:0] w_color;
  assign w_color = color_rd;

  logic push;
  assign push = cmd.scan_eval && hit && w_in && (w_color == 2'd0)
                && (depth < SW'(MAX_VERTICES));

  assign stat.scan_end = (top_s >= edge_total);
  assign stat.conflict = hit && w_in && (w_color != 2'd0) && (w_color == top_c);

  logic [VW-1:0] color_wa;
  logic [1:0]    color_wd;
  logic          color_we;
  always_comb begin
    color_we = 1'b0;
    color_wa = clr_idx;
    color_wd = 2'd0;
    if (cmd.clear_color) begin
      color_we = 1'b1;
    end else if (cmd.start_vtx) begin
      color_we = 1'b1;
      color_wa = VW'(start_v);
      color_wd = 2'd1;
    end else if (cmd.scan_eval && hit && w_in && w_color == 2'd0) begin
      color_we = 1'b1;
      color_wa = w;
      color_wd = 2'd3 - top_c;
    end
  end

  // Color read address: start vertex during start checks, else neighbor of edge_rd
  logic [VW-1:0] color_ra;
  assign color_ra = cmd.next_start ? VW'(start_v + 1'b1) : w;

  // the sweep leaves every vertex uncolored, so the first start check reads zero
  always_ff @(posedge clk) begin
    if (color_we) color_mem[color_wa] <= color_wd;
    if (cmd.clear_color)                     color_rd <= 2'd0;
    else if (cmd.next_start || cmd.scan_req) color_rd <= color_mem[color_ra];
  end

  assign stat.start_colored = (color_rd != 2'd0);

  always_ff @(posedge clk) begin
    if (rst || !cmd.clear_color) begin
      if (rst) begin clr_idx <= '0; clear_done <= 1'b0; end
      else if (!cmd.clear_color) begin clr_idx <= '0; clear_done <= 1'b0; end
    end else begin
      clr_idx    <= clr_idx + 1'b1;
      clear_done <= (clr_idx == VW'(MAX_VERTICES - 2));
    end
  end
  assign stat.clear_done = clear_done;

  // Stack
  logic [SW-1:0] depth_m1;
  assign depth_m1 = depth - 1'b1;
  always_ff @(posedge clk) begin
    if (push) begin
      stk_s[depth_m1[VW-1:0]] <= top_s + 1'b1;
      stk_v[depth[VW-1:0]]    <= w;
    end else if (cmd.start_vtx) begin
      stk_v[0] <= VW'(start_v);
    end
    if (cmd.pop) begin
      top_v <= stk_v[depth_m1[VW-1:0] - 1'b1];
      top_s <= stk_s[depth_m1[VW-1:0] - 1'b1];
    end else if (cmd.start_vtx) begin
      top_v <= VW'(start_v);
      top_s <= '0;
    end else if (push) begin
      top_v <= w;
      top_s <= '0;
    end else if (cmd.scan_eval) begin
      top_s <= top_s + 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      depth  <= '0;
      reload <= 1'b0;
    end else begin
      reload <= cmd.pop;
      if (cmd.start_vtx)     depth <= SW'(1);
      else if (push)         depth <= depth + 1'b1;
      else if (cmd.pop)      depth <= depth_m1;
    end
  end

  // Top color: read when the top frame changes
  always_ff @(posedge clk) begin
    if (cmd.start_vtx)  top_c <= 2'd1;
    else if (push)      top_c <= 2'd3 - top_c;
    else if (reload)    top_c <= color_mem[top_v];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_color) start_v <= (BW+1)'(1);
    else if (cmd.next_start)    start_v <= start_v + 1'b1;
  end
  assign stat.start_done  = (start_v > (BW+1)'(bound));
  assign stat.stack_empty = (depth == '0);
  assign stat.error_seen  = error_seen;

  // A fresh top frame after a pop reloads its color from the color memory
  // (the controller's next scan step check covers that reload).
endmodule

/* rtl/core/bgc_ctrl.sv */
module bgc_ctrl
  import bgc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      in_present,
  input  logic      in_last,
  output logic      out_valid,
  input  logic      out_ready,
  output logic      out_bip,
  output logic      out_err,
  output bgc_cmd_t  cmd,
  input  bgc_stat_t stat
);
  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_CLEAR = 4'd2;
  localparam logic [3:0] S_START = 4'd3;
  localparam logic [3:0] S_REQ   = 4'd4;
  localparam logic [3:0] S_EVAL  = 4'd5;
  localparam logic [3:0] S_DONE  = 4'd6;
  localparam logic [3:0] S_CHK   = 4'd7;
  localparam logic [3:0] S_COL   = 4'd8;

  logic [3:0] state, state_next;
  logic       bip, bip_next;
  logic       acc;
  logic       fire;    // result register free, verdict goes out

  assign acc      = in_valid && in_ready;
  assign in_ready = (state == S_LOAD);
  assign fire     = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    bip_next   = bip;
    cmd        = '0;
    unique case (state)
      S_LOAD: begin
        cmd.load_edge = acc;
        if (acc && in_last) state_next = S_DEC;
      end
      S_DEC: begin
        if (stat.error_seen) begin
          bip_next   = 1'b0;
          state_next = S_DONE;
        end else begin
          state_next = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd.clear_color = 1'b1;
        if (stat.clear_done) begin
          cmd.next_start  = 1'b0;
          state_next      = S_CHK;
        end
      end
      S_CHK: begin
        // start vertex color was read by the previous next_start, except first
        if (stat.start_done) begin
          bip_next   = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_START;
        end
      end
      S_START: begin
        if (stat.start_colored) begin
          cmd.next_start = 1'b1;
          state_next     = S_CHK;
        end else begin
          cmd.start_vtx = 1'b1;
          state_next    = S_REQ;
        end
      end
      S_REQ: begin
        if (stat.stack_empty) begin
          cmd.next_start = 1'b1;
          state_next     = S_CHK;
        end else if (stat.scan_end) begin
          cmd.pop    = 1'b1;
        end else begin
          state_next = S_COL;
        end
      end
      S_COL: begin
        // edge word of the top frame is registered now; fetch neighbor color
        cmd.scan_req = 1'b1;
        state_next   = S_EVAL;
      end
      S_EVAL: begin
        cmd.scan_eval = 1'b1;
        if (stat.conflict) begin
          bip_next   = 1'b0;
          state_next = S_DONE;
        end else begin
          state_next = S_REQ;
        end
      end
      S_DONE: begin
        if (fire) begin
          cmd.finish = 1'b1;
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      bip       <= 1'b0;
      out_valid <= 1'b0;
      out_err   <= 1'b0;
      out_bip   <= 1'b0;
    end else begin
      state <= state_next;
      bip   <= bip_next;
      if (fire) begin
        out_valid <= 1'b1;
        out_bip   <= bip;
        out_err   <= stat.error_seen;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_result_once: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid) else $error("result not raised");
  a_no_accept_walk: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> !in_ready) else $error("accept during walk");
  a_err_result: assert property (@(posedge clk) disable iff (rst)
    (fire && stat.error_seen) |=> (out_err && !out_bip)) else $error("error result bip");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable({out_bip, out_err})))
    else $error("waiting result changed");
endmodule

/* rtl/core/bipartite_graph_check_top.sv */
// Channel   Dir  Handshake      Payload
// edges     in   valid/ready    edge_present, end_a, end_b, last_edge
// result    out  valid/ready    is_bipartite, load_error
// cfg       in   valid/ready    vertex_count
//
// Loading takes one edge item per cycle while in the load state. An item with
// last_edge ends the graph: a decision step, then (no load error) a color clear
// sweep over all MAX_VERTICES entries, a check and a start step per start vertex
// (one more after a walk from it), and per visited vertex an edge read, neighbor
// color read and evaluate per stored edge, plus a frame pop; the result comes last.
// Reset (rst, synchronous) empties the edge count and error flag; vertex_count
// returns to 255. Edges of the next graph are accepted while a result waits; none
// while the walk runs, and a new result waits until the previous one is taken.
module bipartite_graph_check_top
  import bgc_pkg::*;
#(
  parameter int MAX_VERTICES = 256,
  parameter int MAX_EDGES    = 1024
) (
  input logic   clk,
  input logic   rst,
  bgc_edge_if.sink     edges,
  bgc_result_if.source result,
  bgc_cfg_if.sink      cfg
);
  bgc_cmd_t         cmd;
  bgc_stat_t        stat;
  logic [VTX_W-1:0] vertex_count;

  // configuration register, always ready
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst)            vertex_count <= VTX_W'(255);
    else if (cfg.valid) vertex_count <= cfg.vertex_count;
  end

  bgc_ctrl u_ctrl (
    .clk, .rst,
    .in_valid  (edges.valid),
    .in_ready  (edges.ready),
    .in_present(edges.edge_present),
    .in_last   (edges.last_edge),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_bip   (result.is_bipartite),
    .out_err   (result.load_error),
    .cmd, .stat
  );

  bgc_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk, .rst, .cmd, .stat,
    .in_present  (edges.edge_present),
    .in_a        (edges.end_a),
    .in_b        (edges.end_b),
    .vertex_count(vertex_count)
  );
endmodule

/* tb/testbench.sv */
module testbench;
  import bgc_pkg::*;

  localparam int MAX_V = 256;
  localparam int MAX_E = 1024;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int HOLD_CYCLES = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  bgc_edge_if   edges();
  bgc_result_if result();
  bgc_cfg_if    cfg();

  bipartite_graph_check_top #(.MAX_VERTICES(MAX_V), .MAX_EDGES(MAX_E)) dut (
    .clk(clk), .rst(rst), .edges(edges.sink), .result(result.source), .cfg(cfg.sink)
  );

  // Predicted verdicts, oldest first
  typedef struct packed {
    logic is_bipartite;
    logic load_error;
  } verdict_t;

  verdict_t verdict_q[$];

  // Shadow copy of the block state
  logic [7:0] sh_vcount;
  logic [7:0] sh_store_a[MAX_E];
  logic [7:0] sh_store_b[MAX_E];
  int         sh_total;
  logic       sh_error;

  int mismatches = 0;
  int idle_pct = 0;    // sender idle percentage
  int stall_pct = 0;   // receiver stall percentage
  bit hold_off = 0;    // long receiver hold-off in progress
  int quiet_cycles = 0;

  initial begin
    edges.valid = 0;
    edges.edge_present = 0;
    edges.end_a = 0;
    edges.end_b = 0;
    edges.last_edge = 0;
    cfg.valid = 0;
    cfg.vertex_count = 0;
  end

  function automatic int vbound();
    return (sh_vcount > MAX_V - 1) ? MAX_V - 1 : sh_vcount;
  endfunction

  // Two-color walk over the shadow store, same order as the block:
  // explicit stack of (vertex, scan) frames.
  function automatic logic two_color_walk();
    logic [1:0] color[MAX_V];
    int stk_v[MAX_V];
    int stk_s[MAX_V];
    int depth, u, w, top, bnd;
    bnd = vbound();
    for (int i = 0; i < MAX_V; i++) color[i] = 0;
    for (int v = 1; v <= bnd; v++) begin
      if (color[v] != 0) continue;
      color[v] = 1;
      stk_v[0] = v;
      stk_s[0] = 0;
      depth = 1;
      while (depth > 0) begin
        top = depth - 1;
        u = stk_v[top];
        if (stk_s[top] >= sh_total) begin
          depth--;
          continue;
        end
        if (sh_store_a[stk_s[top]] == u) w = sh_store_b[stk_s[top]];
        else if (sh_store_b[stk_s[top]] == u) w = sh_store_a[stk_s[top]];
        else begin
          stk_s[top]++;
          continue;
        end
        stk_s[top]++;
        if (color[w] == 0) begin
          color[w] = 2'd3 - color[u];
          if (depth < MAX_V) begin
            stk_v[depth] = w;
            stk_s[depth] = 0;
            depth++;
          end
        end else if (color[w] == color[u]) begin
          return 1'b0;
        end
      end
    end
    return 1'b1;
  endfunction

  // Update the shadow for one accepted edge item
  task automatic predict_edge_item(logic pres, logic [7:0] a, logic [7:0] b, logic last);
    verdict_t vd;
    int bnd;
    bnd = vbound();
    if (pres) begin
      if (a < 1 || a > bnd || b < 1 || b > bnd) sh_error = 1;
      else if (sh_total >= MAX_E) sh_error = 1;
      else begin
        sh_store_a[sh_total] = a;
        sh_store_b[sh_total] = b;
        sh_total++;
      end
    end
    if (last) begin
      if (sh_error) begin
        vd.is_bipartite = 0;
        vd.load_error = 1;
      end else begin
        vd.is_bipartite = two_color_walk();
        vd.load_error = 0;
      end
      verdict_q.insert(verdict_q.size(), vd);
      sh_total = 0;
      sh_error = 0;
    end
  endtask

  // Offer one item, with random sender gaps, and wait for its acceptance;
  // valid stays up after acceptance so items can follow back to back
  task automatic send_edge(logic pres, logic [7:0] a, logic [7:0] b, logic last);
    while ($urandom_range(99) < idle_pct) begin
      edges.valid <= 0;
      @(posedge clk);
    end
    edges.valid <= 1;
    edges.edge_present <= pres;
    edges.end_a <= a;
    edges.end_b <= b;
    edges.last_edge <= last;
    @(posedge clk);
    while (!edges.ready) @(posedge clk);
    predict_edge_item(pres, a, b, last);
  endtask

  task automatic wait_drained();
    edges.valid <= 0;
    while (verdict_q.size() != 0) @(posedge clk);
    // the walk of an errored graph or a dangling item may still be busy
    repeat (50) @(posedge clk);
  endtask

  // Register write, only while the block is idle
  task automatic write_vcount(logic [7:0] n);
    wait_drained();
    cfg.valid <= 1;
    cfg.vertex_count <= n;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 0;
    sh_vcount = n;
  endtask

  function automatic logic [7:0] rand_vertex(int hi);
    return 8'($urandom_range(hi, 1));
  endfunction

  // Random graph: mostly clean edges, sometimes bad endpoints
  task automatic send_random_graph(int n_edges, int hi, bit noisy);
    logic [7:0] a, b;
    for (int i = 0; i < n_edges; i++) begin
      a = rand_vertex(hi);
      b = rand_vertex(hi);
      if (noisy && $urandom_range(19) == 0) a = 8'($urandom_range(255));
      if ($urandom_range(29) == 0) begin
        send_edge(0, 8'($urandom), 8'($urandom), 0);   // filler, ignored
      end
      send_edge(1, a, b, 0);
    end
    if ($urandom_range(1)) send_edge(1, rand_vertex(hi), rand_vertex(hi), 1);
    else send_edge(0, 8'($urandom), 8'($urandom), 1);
  endtask

  // Bipartite by construction: odd vertices to even ones
  task automatic send_even_odd_graph(int n_edges, int hi);
    logic [7:0] a, b;
    for (int i = 0; i < n_edges; i++) begin
      a = 8'($urandom_range(hi - 1, 1) | 1);
      if (a > hi) a = 1;
      b = 8'($urandom_range(hi, 2) & 32'hFE);
      if (b < 2) b = 2;
      send_edge(1, a, b, i == n_edges - 1);
    end
  endtask

  task automatic test_directed();
    write_vcount(8'd255);
    send_edge(0, 0, 0, 1);                  // empty graph
    send_edge(1, 1, 1, 1);                  // self loop
    send_edge(1, 1, 2, 0);                  // triangle
    send_edge(1, 2, 3, 0);
    send_edge(1, 3, 1, 1);
    send_edge(1, 255, 254, 0);              // top vertices, path
    send_edge(1, 254, 253, 1);
    send_edge(1, 0, 5, 1);                  // vertex zero
    send_edge(1, 1, 2, 0);                  // bad edge mid graph
    send_edge(1, 7, 0, 0);
    send_edge(1, 2, 3, 1);
    send_edge(0, 8'hAA, 8'h55, 0);          // ignored item
    send_edge(1, 8'hAA, 8'h55, 1);
    write_vcount(8'd1);
    send_edge(1, 1, 1, 1);
    send_edge(1, 1, 2, 1);                  // out of range
    write_vcount(8'd10);
    send_edge(1, 1, 10, 0);
    send_edge(1, 10, 3, 0);
    send_edge(1, 3, 1, 1);
    send_edge(1, 11, 2, 1);
    // register lowered after loading: walk still follows high vertices
    send_edge(1, 1, 9, 0);
    send_edge(1, 9, 2, 0);
    send_edge(1, 2, 1, 0);
    write_vcount(8'd2);
    send_edge(0, 0, 0, 1);
  endtask

  // Store filled to the last entry, then one edge more on the final item
  task automatic test_overflow();
    write_vcount(8'd4);
    for (int i = 0; i < MAX_E; i++) send_edge(1, rand_vertex(4), rand_vertex(4), 0);
    send_edge(1, 8'd1, 8'd2, 1);
  endtask

  task automatic random_phase(int n_items);
    int sent;
    int hi, n;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(7) == 0) write_vcount(8'($urandom_range(255, 1)));
      hi = vbound();
      n = $urandom_range(12);
      if ($urandom_range(2) == 0 && hi >= 2) send_even_odd_graph(n + 1, hi);
      else send_random_graph(n, hi, $urandom_range(3) == 0);
      sent += n + 1;
    end
  endtask

  task automatic test_random();
    idle_pct = 0;  stall_pct = 0;  random_phase(120);
    idle_pct = 61; stall_pct = 0;  random_phase(120);
    idle_pct = 0;  stall_pct = 61; random_phase(120);
    idle_pct = 12; stall_pct = 12; random_phase(120);
  endtask

  // Receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    idle_pct = 0; stall_pct = 0;
    write_vcount(8'd255);
    hold_off = 1;
    for (int g = 0; g < 4; g++) send_random_graph(3, 255, 0);
    wait_drained();   // sender pause until all verdicts are in
    send_even_odd_graph(5, 255);
  endtask

  // Hold-off counter in its own process; releases the receiver when done
  initial begin
    int cnt;
    cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        cnt++;
        if (cnt >= HOLD_CYCLES) begin
          hold_off = 0;
          cnt = 0;
        end
      end else begin
        cnt = 0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) result.ready <= 0;
    else if (hold_off) result.ready <= 0;
    else result.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Result checker
  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst && result.valid && result.ready) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected verdict %0b/%0b",
                                       result.is_bipartite, result.load_error);
      end else begin
        exp_v = verdict_q.pop_front();
        if (exp_v.is_bipartite !== result.is_bipartite ||
            exp_v.load_error !== result.load_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("verdict mismatch: exp bip=%0b err=%0b got bip=%0b err=%0b",
                     exp_v.is_bipartite, exp_v.load_error,
                     result.is_bipartite, result.load_error);
        end
      end
    end
  end

  // Watchdog: cycles with no handshake at all
  always @(posedge clk) begin
    if ((edges.valid && edges.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    sh_vcount = 8'd255;
    sh_total = 0;
    sh_error = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_random();
    test_backpressure();
    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* bipartite_graph_check_top.f */
rtl/core/bgc_pkg.sv
rtl/core/bgc_if.sv
rtl/core/bgc_datapath.sv
rtl/core/bgc_ctrl.sv
rtl/core/bipartite_graph_check_top.sv
tb/testbench.sv
